FILE: src/afr_pkg.sv
// Shared types and constants of the attitude frame receiver.
package afr_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'h39;
  localparam logic [7:0] TAIL_BYTE = 8'hFF;

  localparam int FRAME_LEN = 27;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int TAIL_POS  = 22;
  localparam int SPEED_POS = 16;
  localparam int STAMP_POS = 23;
  localparam int COLOR_POS = 20;
  localparam int MODE_POS  = 21;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_USE_FIXED  = 1'b0;
  localparam logic CFG_FIXED_BITS = 1'b1;

  // One payload byte as handed from the front to the back.
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic [7:0]       data;
  } afr_item_t;

  // Decoded result of one good frame.
  typedef struct packed {
    logic [31:0] time_stamp;
    logic [1:0]  aim_mode;
    logic [7:0]  target_colour;
    logic [31:0] speed_bits;
    logic [31:0] quat_z_bits;
    logic [31:0] quat_y_bits;
    logic [31:0] quat_x_bits;
    logic [31:0] quat_w_bits;
  } afr_result_t;

endpackage

FILE: src/attitude_frame_receiver.sv
// Top level of the attitude frame receiver: ports, configuration and wiring.
//
// The attitude frame receiver takes one serial byte per stream transaction and
// turns frames of the form 0x39 0x39 followed by 27 payload bytes into decoded
// attitude results. It accepts one byte in every clock cycle for as long as the
// result side keeps up; the input only stalls when the four-entry queue between
// the header hunter and the frame decoder is full, and that queue only fills
// while a finished result is waiting to be taken. The final payload byte of a
// frame passes through the queue and then into the result register, and frames
// whose payload byte 22 is not 0xFF are dropped without any output. Payload
// bytes are never checked for headers.
// Configuration writes (index 0: use the fixed bullet speed, index 1: its
// single-precision bit pattern) are always accepted and should be made while
// no frame is in flight.
module attitude_frame_receiver import afr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // Received bytes.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // [7:0] rx_byte
  // Decoded frames.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [207:0] m_tdata,    // [31:0] quat_w_bits, [63:32] quat_x_bits,
                                   // [95:64] quat_y_bits, [127:96] quat_z_bits,
                                   // [159:128] speed_bits, [167:160] target_colour,
                                   // [169:168] aim_mode, [201:170] time_stamp,
                                   // [207:202] zero
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic        use_fixed_speed;
  logic [31:0] fixed_speed_bits;

  logic        fifo_full;
  logic        fifo_not_empty;
  logic        push;
  logic        pop;
  afr_item_t   push_item;
  afr_item_t   head;
  afr_result_t result;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_fixed_speed  <= 1'b0;
      fixed_speed_bits <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_USE_FIXED:  use_fixed_speed  <= cfg_data[0];
        CFG_FIXED_BITS: fixed_speed_bits <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Bytes are taken whenever the queue has room, also during the header hunt,
  // so that the hunt never waits on a result that has not been collected.
  assign s_tready = !fifo_full;

  afr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (s_tvalid && s_tready),
    .rx_byte (s_tdata),
    .push    (push),
    .item    (push_item)
  );

  afr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (fifo_full),
    .not_empty (fifo_not_empty),
    .head      (head)
  );

  afr_back u_back (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (fifo_not_empty),
    .item             (head),
    .pop              (pop),
    .use_fixed_speed  (use_fixed_speed),
    .fixed_speed_bits (fixed_speed_bits),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .result           (result)
  );

  // The result struct is laid out with the first field in the highest bits.
  assign m_tdata = {6'd0, result};

endmodule

FILE: src/afr_front.sv
// Front end: header hunt and payload byte numbering.
module afr_front import afr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] rx_byte,
  output logic      push,
  output afr_item_t item
);

  logic             in_payload;
  logic [7:0]       prev_byte;
  logic [IDX_W-1:0] byte_index;
  logic             is_last;

  assign is_last    = (byte_index == LAST_IDX);
  assign push       = accept && in_payload;
  assign item.index = byte_index;
  assign item.last  = is_last;
  assign item.data  = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      prev_byte  <= '0;
      byte_index <= '0;
    end else if (accept) begin
      if (!in_payload) begin
        if (prev_byte == HDR_BYTE && rx_byte == HDR_BYTE) begin
          in_payload <= 1'b1;
          byte_index <= '0;
          prev_byte  <= '0;
        end else begin
          prev_byte <= rx_byte;
        end
      end else if (is_last) begin
        in_payload <= 1'b0;
        byte_index <= '0;
        prev_byte  <= '0;
      end else begin
        byte_index <= byte_index + 1'b1;
      end
    end
  end

endmodule

FILE: src/afr_fifo.sv
// Short queue of payload bytes between the front and the back.
module afr_fifo import afr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  afr_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output afr_item_t head
);

  afr_item_t             entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/afr_back.sv
// Back end: payload store, tail check, field decode and result register.
module afr_back import afr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  afr_item_t   item,
  output logic        pop,
  input  logic        use_fixed_speed,
  input  logic [31:0] fixed_speed_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output afr_result_t result
);

  // The final byte is used straight from the queue, so the store holds one less.
  logic [7:0]  store [FRAME_LEN-1];
  logic        emit;
  logic [7:0]  mode_byte;
  afr_result_t decoded;

  function automatic logic [31:0] be32(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3);
    return {b0, b1, b2, b3};
  endfunction

  // A last byte waits while a result is still unclaimed; other bytes always go.
  assign pop  = item_valid && (!item.last || !out_valid || out_ready);
  assign emit = pop && item.last && (store[TAIL_POS] == TAIL_BYTE);

  assign mode_byte = store[MODE_POS];

  always_comb begin
    decoded.quat_w_bits   = be32(store[0], store[1], store[2], store[3]);
    decoded.quat_x_bits   = be32(store[4], store[5], store[6], store[7]);
    decoded.quat_y_bits   = be32(store[8], store[9], store[10], store[11]);
    decoded.quat_z_bits   = be32(store[12], store[13], store[14], store[15]);
    decoded.speed_bits    = use_fixed_speed ? fixed_speed_bits :
                            be32(store[SPEED_POS], store[SPEED_POS+1],
                                 store[SPEED_POS+2], store[SPEED_POS+3]);
    decoded.target_colour = store[COLOR_POS];
    decoded.aim_mode      = (mode_byte > 8'd3) ? 2'd0 : mode_byte[1:0];
    decoded.time_stamp    = be32(store[STAMP_POS], store[STAMP_POS+1],
                                 store[STAMP_POS+2], item.data);
  end

  always_ff @(posedge clk) begin
    if (pop && !item.last) begin
      store[item.index] <= item.data;
    end
    if (emit) begin
      result <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
